// ----- src/nllp_pkg.sv -----
// Shared types and constants for the four-pole nonlinear ladder lowpass.
// Holds register codes, reset values, tanh/divider widths and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nllp_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF  = 32;

    // Configuration port
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd2;
    localparam logic [COEF_W-1:0] CUT_RESET   = 16'd2526;
    localparam logic [COEF_W-1:0] RES_RESET   = 16'd1638;
    localparam logic [COEF_W-1:0] DRIVE_RESET = 16'd4096;

    // Poles
    localparam int NPOLE  = 4;
    localparam int POLE_W = 2;
    localparam logic [POLE_W-1:0] POLE_LAST = 2'd3;

    // Rational tanh, evaluated in Q24
    localparam int TQ        = 24;
    localparam int A_W       = 27;   // signed argument, |a| <= 3.0
    localparam int AMAG_W    = 26;   // its magnitude
    localparam int QT_W      = 31;   // 27 + u^2 and 27 + 9u^2 terms
    localparam int NUM_W     = 55;   // |a| * (27 + u^2)
    localparam int QUO_W     = 26;   // quotient bits
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DCNT_W    = 4;
    localparam logic [16:0] INV_2VT = 17'd105026;  // 1/(2*0.312), Q16
    localparam logic [QT_W-1:0] TQ_27 = QT_W'(27 * (1 << TQ));

    typedef enum logic [2:0] {
        MUL_DRIVE,
        MUL_RES,
        MUL_INV,
        MUL_SQ,
        MUL_NUM,
        MUL_CUT
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              x_lo;
        logic              x_fin;
        logic              clip_u;
        logic              clip_den;
        logic              div_start;
        logic              clip_done;
        logic              pt_wr;
        logic              pole_upd;
        logic [POLE_W-1:0] pole;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/nllp_div.sv -----
// Unsigned restoring divider, two quotient bits per cycle.
// Used for the tanh quotient; depends on nllp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nllp_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [nllp_pkg::NUM_W-1:0]   num,
    input  wire logic [nllp_pkg::QT_W-1:0]    den,
    output logic                              done,
    output logic [nllp_pkg::QUO_W-1:0]        quot
);
    import nllp_pkg::*;

    localparam int SW = QT_W + QUO_W;

    logic [QT_W-1:0]   rem_reg;
    logic [QUO_W-1:0]  nq_reg;
    logic [QT_W-1:0]   den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SW-1:0]     s1;
    logic [SW-1:0]     s2;

    // one shift-compare-subtract step; remainder always below den
    function automatic logic [SW-1:0] div_step(input logic [QT_W-1:0] r,
                                               input logic [QUO_W-1:0] nq,
                                               input logic [QT_W-1:0] d);
        logic [QT_W:0]   t;
        logic [QT_W:0]   diff;
        logic            qb;
        logic [QT_W-1:0] r_o;
        t    = {r, nq[QUO_W-1]};
        diff = t - {1'b0, d};
        qb   = (t >= {1'b0, d});
        r_o  = qb ? diff[QT_W-1:0] : t[QT_W-1:0];
        return {r_o, nq[QUO_W-2:0], qb};
    endfunction

    always_comb
    begin
        s1 = div_step(rem_reg, nq_reg, den_reg);
        s2 = div_step(s1[SW-1:QUO_W], s1[QUO_W-1:0], den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == DCNT_W'(DIV_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= QT_W'(num[NUM_W-1:QUO_W]);
            nq_reg  <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= s2[SW-1:QUO_W];
            nq_reg  <= s2[QUO_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

`default_nettype wire

// ----- src/nllp_dp.sv -----
// Datapath: config registers, pole state, shared multiplier, tanh
// evaluation and output register. Depends on nllp_pkg and nllp_div.
`timescale 1ns / 1ps
`default_nettype none

module nllp_dp
#(
    parameter int SAMPLE_BITS = nllp_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = nllp_pkg::STATE_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [nllp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nllp_pkg::COEF_W-1:0]      cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]    sample_in,
    input  wire nllp_pkg::dp_cmd_t                cmd,
    output nllp_pkg::dp_sts_t                     sts,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out
);
    import nllp_pkg::*;

    localparam int FRAC = STATE_BITS - 5;
    localparam int CW   = FRAC + 4;          // clamped tanh operand
    localparam int TW   = FRAC + 2;          // tanh values
    localparam int DFW  = FRAC + 3;          // tanh differences
    localparam int DW   = STATE_BITS - 2;    // derivatives
    localparam int XW   = STATE_BITS + 4;    // filter input, pole sum
    localparam int MA   = (STATE_BITS + 1 > A_W) ? STATE_BITS + 1 : A_W;
    localparam int MB   = QT_W;
    localparam int PW   = MA + MB + 1;
    localparam int YW   = STATE_BITS + SAMPLE_BITS;

    localparam int DSH = SAMPLE_BITS + 11;
    localparam int LSH = (FRAC >= DSH) ? FRAC - DSH : 0;
    localparam int RSH = (FRAC >= DSH) ? 0 : DSH - FRAC;
    localparam int ALS = (TQ >= FRAC) ? TQ - FRAC : 0;
    localparam int ARS = (TQ >= FRAC) ? 0 : FRAC - TQ;
    localparam int TLS = (FRAC >= TQ) ? FRAC - TQ : 0;
    localparam int TRS = (FRAC >= TQ) ? 0 : TQ - FRAC;
    localparam int OLS = (SAMPLE_BITS - 1 >= FRAC) ? SAMPLE_BITS - 1 - FRAC : 0;
    localparam int ORS = (SAMPLE_BITS - 1 >= FRAC) ? 0 : FRAC - SAMPLE_BITS + 1;

    localparam logic signed [XW-1:0] LIM_X = XW'(1) << (FRAC + 2);
    localparam logic signed [PW-1:0] LIM_U = PW'(3) << FRAC;
    localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC;
    localparam logic signed [XW-1:0] VMAX  = (XW'(1) << (STATE_BITS - 1)) - XW'(1);
    localparam logic signed [XW-1:0] VMIN  = -VMAX - XW'(1);
    localparam logic signed [YW-1:0] YMAX  = (YW'(1) << (SAMPLE_BITS - 1)) - YW'(1);
    localparam logic signed [YW-1:0] YMIN  = -YMAX - YW'(1);

    // config
    logic [COEF_W-1:0] cut_reg;
    logic [COEF_W-1:0] res_reg;
    logic [COEF_W-1:0] drive_reg;

    // filter state
    logic signed [STATE_BITS-1:0] pv_reg [NPOLE];
    logic signed [DW-1:0]         pd_reg [NPOLE];
    logic signed [TW-1:0]         pt_reg [NPOLE];

    // working registers
    logic signed [SAMPLE_BITS-1:0] s_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [XW-1:0]          xd_reg;
    logic signed [CW-1:0]          clip_op_reg;
    logic [AMAG_W-1:0]             a_mag_reg;
    logic                          neg_reg;
    logic                          sat_reg;
    logic                          satneg_reg;
    logic [QT_W-1:0]               sqterm_reg;
    logic [QT_W-1:0]               den_reg;
    logic signed [TW-1:0]          t_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          out_valid_reg;

    // combinational
    logic signed [STATE_BITS-1:0] pv_rd;
    logic signed [DW-1:0]         pd_rd;
    logic signed [TW-1:0]         pt_rd;
    logic signed [DFW-1:0]        t_ext;
    logic signed [DFW-1:0]        pt_ext;
    logic signed [DFW-1:0]        diff_op;
    logic signed [MA-1:0]         mul_a;
    logic [MB-1:0]                mul_b;
    logic signed [PW-1:0]         prod_next;
    logic signed [PW-1:0]         drv_al;
    logic signed [XW-1:0]         x_sum;
    logic signed [PW-1:0]         u_w;
    logic signed [PW-1:0]         a_w;
    logic signed [A_W-1:0]        a27;
    logic signed [A_W-1:0]        a_abs;
    logic [QT_W-1:0]              sq31;
    logic signed [A_W-1:0]        tq;
    logic signed [PW-1:0]         t_wide;
    logic signed [TW-1:0]         t_new;
    logic signed [DW-1:0]         d_new;
    logic signed [XW-1:0]         v_sum;
    logic signed [STATE_BITS-1:0] v_new;
    logic signed [YW-1:0]         y_w;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic [QUO_W-1:0]             div_quot;
    logic                         div_done;

    // beyond |x| = 4 the scaled argument is past 3, so tanh is already +-1
    function automatic logic signed [CW-1:0] clamp4(input logic signed [XW-1:0] x);
        logic signed [CW-1:0] r;
        if (x > LIM_X)
            r = CW'(LIM_X);
        else if (x < -LIM_X)
            r = -CW'(LIM_X);
        else
            r = CW'(x);
        return r;
    endfunction

    always_comb
    begin
        pv_rd  = pv_reg[cmd.pole];
        pd_rd  = pd_reg[cmd.pole];
        pt_rd  = pt_reg[cmd.pole];
        t_ext  = DFW'(t_reg);
        pt_ext = DFW'(pt_rd);
        // first pole: negated sum folds the sign of its derivative in
        if (cmd.pole == '0)
            diff_op = -(t_ext + pt_ext);
        else
            diff_op = t_ext - pt_ext;

        case (cmd.mul_sel)
            MUL_DRIVE:
            begin
                mul_a = MA'(s_reg);
                mul_b = MB'(drive_reg);
            end
            MUL_RES:
            begin
                mul_a = MA'(pv_rd);
                mul_b = MB'(res_reg);
            end
            MUL_INV:
            begin
                mul_a = MA'(clip_op_reg);
                mul_b = MB'(INV_2VT);
            end
            MUL_SQ:
            begin
                mul_a = MA'($signed({1'b0, a_mag_reg}));
                mul_b = MB'(a_mag_reg);
            end
            MUL_NUM:
            begin
                mul_a = MA'($signed({1'b0, a_mag_reg}));
                mul_b = sqterm_reg;
            end
            MUL_CUT:
            begin
                mul_a = MA'(diff_op);
                mul_b = MB'(cut_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * $signed({1'b0, mul_b});

        drv_al = (prod_reg <<< LSH) >>> RSH;
        x_sum  = xd_reg + XW'(prod_reg >>> 14);

        u_w   = prod_reg >>> 16;
        a_w   = (u_w <<< ALS) >>> ARS;
        a27   = a_w[A_W-1:0];
        a_abs = a27[A_W-1] ? -a27 : a27;

        sq31 = prod_reg[TQ +: QT_W];

        tq     = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        t_wide = (PW'(tq) <<< TLS) >>> TRS;
        if (sat_reg)
            t_new = satneg_reg ? -ONE_T : ONE_T;
        else
            t_new = TW'(t_wide);

        d_new = DW'(prod_reg >>> 16);
        v_sum = XW'(pv_rd) + XW'(d_new) + XW'(pd_rd);
        if (v_sum > VMAX)
            v_new = STATE_BITS'(VMAX);
        else if (v_sum < VMIN)
            v_new = STATE_BITS'(VMIN);
        else
            v_new = STATE_BITS'(v_sum);

        y_w = (YW'(pv_rd) <<< OLS) >>> ORS;
        if (y_w > YMAX)
            y_sat = SAMPLE_BITS'(YMAX);
        else if (y_w < YMIN)
            y_sat = SAMPLE_BITS'(YMIN);
        else
            y_sat = SAMPLE_BITS'(y_w);
    end

    nllp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_reg[NUM_W-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // config, filter state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg       <= CUT_RESET;
            res_reg       <= RES_RESET;
            drive_reg     <= DRIVE_RESET;
            pv_reg        <= '{default: '0};
            pd_reg        <= '{default: '0};
            pt_reg        <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CUT:   cut_reg   <= cfg_data;
                    REG_RES:   res_reg   <= cfg_data;
                    REG_DRIVE: drive_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.pole_upd)
            begin
                pv_reg[cmd.pole] <= v_new;
                pd_reg[cmd.pole] <= d_new;
            end
            if (cmd.clip_done && cmd.pt_wr)
                pt_reg[cmd.pole] <= t_new;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            s_reg <= sample_in;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.x_lo)
            xd_reg <= XW'(drv_al);
        if (cmd.x_fin)
            clip_op_reg <= clamp4(x_sum);
        else if (cmd.pole_upd)
            clip_op_reg <= clamp4(XW'(v_new));
        if (cmd.clip_u)
        begin
            sat_reg    <= (u_w >= LIM_U) || (u_w <= -LIM_U);
            satneg_reg <= u_w[PW-1];
            neg_reg    <= a27[A_W-1];
            a_mag_reg  <= a_abs[AMAG_W-1:0];
        end
        if (cmd.clip_den)
        begin
            sqterm_reg <= TQ_27 + sq31;
            den_reg    <= TQ_27 + (sq31 << 3) + sq31;
        end
        if (cmd.clip_done)
            t_reg <= t_new;
        if (cmd.out_load)
            out_reg <= y_sat;
    end

    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign sample_out   = out_reg;

endmodule

`default_nettype wire

// ----- src/nllp_ctrl.sv -----
// Sequencer for one sample: input mix, five tanh evaluations, four pole
// updates and the output load. Depends on nllp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nllp_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output nllp_pkg::dp_cmd_t        cmd,
    input  wire nllp_pkg::dp_sts_t   sts
);
    import nllp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRV,
        S_RES,
        S_XF,
        S_MINV,
        S_ARG,
        S_MSQ,
        S_DEN,
        S_MNUM,
        S_DSTART,
        S_DIV,
        S_PMUL,
        S_PUPD,
        S_FIN
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [POLE_W-1:0] pole_reg;
    logic [POLE_W-1:0] pole_next;
    logic              phase_reg;   // tanh in flight is for the filter input
    logic              phase_next;

    always_comb
    begin
        state_next = state_reg;
        pole_next  = pole_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DRIVE;
        cmd.pole    = (state_reg == S_RES) ? POLE_LAST : pole_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    pole_next   = '0;
                    phase_next  = 1'b1;
                    state_next  = S_DRV;
                end
            end
            S_DRV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DRIVE;
                state_next  = S_RES;
            end
            S_RES:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RES;
                cmd.x_lo    = 1'b1;
                state_next  = S_XF;
            end
            S_XF:
            begin
                cmd.x_fin  = 1'b1;
                state_next = S_MINV;
            end
            S_MINV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INV;
                state_next  = S_ARG;
            end
            S_ARG:
            begin
                cmd.clip_u = 1'b1;
                state_next = S_MSQ;
            end
            S_MSQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_DEN;
            end
            S_DEN:
            begin
                cmd.clip_den = 1'b1;
                state_next   = S_MNUM;
            end
            S_MNUM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NUM;
                state_next  = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.clip_done = 1'b1;
                    cmd.pt_wr     = !phase_reg;
                    if (phase_reg)
                    begin
                        phase_next = 1'b0;
                        state_next = S_PMUL;
                    end
                    else if (pole_reg == POLE_LAST)
                        state_next = S_FIN;
                    else
                    begin
                        pole_next  = pole_reg + 1'b1;
                        state_next = S_PMUL;
                    end
                end
            end
            S_PMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CUT;
                state_next  = S_PUPD;
            end
            S_PUPD:
            begin
                cmd.pole_upd = 1'b1;
                state_next   = S_MINV;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pole_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pole_reg  <= pole_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the wait state");

    a_div_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && !sts.div_done |=> state_reg == S_DIV)
        else $error("left divider wait without a quotient");

    a_fin_last_pole: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> pole_reg == POLE_LAST)
        else $error("output stage reached before the last pole");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && in_valid |=>
            (state_reg == S_DRV) && phase_reg && (pole_reg == '0))
        else $error("accepted transaction did not start a fresh pass");
`endif

endmodule

`default_nettype wire

// ----- src/nonlinear_ladder_lowpass_4pole_top.sv -----
// Top level of the four-pole nonlinear ladder lowpass.
// Instantiates nllp_ctrl and nllp_dp; depends on nllp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Four-pole nonlinear ladder lowpass with trapezoidal integration. Each input
// transaction carries one signed Q1.15 sample; each output transaction returns
// the last pole voltage, floored and saturated to SAMPLE_BITS. The filter
// input is drive*sample plus resonance times the last pole; every pole is
// driven through a rational tanh, x(27+x^2)/(27+9x^2), clamped to +-1 at |x|>=3.
// One sample is worked on at a time; the cost is five tanh evaluations,
// dominated by the divider (two quotient bits per cycle), plus the input
// mix, the four pole updates and the output load. One shared multiplier
// (about 33 x 32 bits, registered) serves every product.
// in_ready is high whenever the sequencer is idle, so a new sample is taken
// while the previous result still waits in the output register; the pass only
// stalls at its very end if that result has not been taken.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 cut_coef (Q0.16),
// 1 resonance (Q2.14), 2 drive (Q4.12); other indexes are ignored. Write only
// while no transaction is in flight. Pole state resets to zero.
module nonlinear_ladder_lowpass_4pole_top
#(
    parameter int SAMPLE_BITS = nllp_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = nllp_pkg::STATE_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [nllp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nllp_pkg::COEF_W-1:0]      cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    sample_in,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out
);
    import nllp_pkg::*;

    dp_cmd_t cmd;   // sequencer commands
    dp_sts_t sts;   // divider and output-slot status

    nllp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    nllp_dp
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire
